>>> rtl/core/nlp_pkg.sv
// shared types, constants and the microcode rom of the permutation stepper
package nlp_pkg;

    localparam int MAX_LENGTH  = 16;
    localparam int ELEM_W      = 8;
    localparam int ADDR_W      = $clog2(MAX_LENGTH);
    localparam int CNT_W       = $clog2(MAX_LENGTH + 1);
    localparam int STEP_W      = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int SIZE_W      = 5;
    localparam int SIZE_RESET  = 16;

    typedef logic [STEP_W-1:0] t_step;

    // action codes carried on the input tuser
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // program addresses used as jump targets
    localparam t_step ST_IDLE   = t_step'(0);
    localparam t_step ST_RD_IM1 = t_step'(3);
    localparam t_step ST_WRAP   = t_step'(6);
    localparam t_step ST_FIND   = t_step'(7);
    localparam t_step ST_REV    = t_step'(11);
    localparam t_step ST_EMIT0  = t_step'(16);
    localparam t_step ST_RD_K   = t_step'(17);
    localparam t_step ST_EMIT   = t_step'(18);

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_RD_I,
        OP_LD_PREV,
        OP_RD_IM1,
        OP_CMP_ASC,
        OP_NOP,
        OP_WRAP,
        OP_RD_J,
        OP_TEST_J,
        OP_WR_PIV_J,
        OP_WR_CUR_IM1,
        OP_REV_CHK,
        OP_RD_LO,
        OP_RD_HI,
        OP_SWAP1,
        OP_SWAP2,
        OP_EMIT_INIT,
        OP_RD_K,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_START,
        C_I_ZERO,
        C_I_NZ,
        C_ASC,
        C_J_LE,
        C_REV_DONE,
        C_OUT_BUSY,
        C_K_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // datapath flags sampled by the sequencer's jump logic
    typedef struct packed {
        logic start;
        logic asc;
        logic i_zero;
        logic j_le;
        logic rev_done;
        logic out_busy;
        logic k_more;
    } t_status;

    function automatic t_uword ucode(input t_step addr);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
        case (addr)
            5'd0:  w = '{op: OP_IDLE,       cond: C_NOT_START, target: ST_IDLE};
            5'd1:  w = '{op: OP_RD_I,       cond: C_NEVER,     target: ST_IDLE};
            5'd2:  w = '{op: OP_LD_PREV,    cond: C_I_ZERO,    target: ST_WRAP};
            5'd3:  w = '{op: OP_RD_IM1,     cond: C_NEVER,     target: ST_IDLE};
            5'd4:  w = '{op: OP_CMP_ASC,    cond: C_ASC,       target: ST_FIND};
            5'd5:  w = '{op: OP_NOP,        cond: C_I_NZ,      target: ST_RD_IM1};
            5'd6:  w = '{op: OP_WRAP,       cond: C_ALWAYS,    target: ST_REV};
            5'd7:  w = '{op: OP_RD_J,       cond: C_NEVER,     target: ST_IDLE};
            5'd8:  w = '{op: OP_TEST_J,     cond: C_J_LE,      target: ST_FIND};
            5'd9:  w = '{op: OP_WR_PIV_J,   cond: C_NEVER,     target: ST_IDLE};
            5'd10: w = '{op: OP_WR_CUR_IM1, cond: C_NEVER,     target: ST_IDLE};
            5'd11: w = '{op: OP_REV_CHK,    cond: C_REV_DONE,  target: ST_EMIT0};
            5'd12: w = '{op: OP_RD_LO,      cond: C_NEVER,     target: ST_IDLE};
            5'd13: w = '{op: OP_RD_HI,      cond: C_NEVER,     target: ST_IDLE};
            5'd14: w = '{op: OP_SWAP1,      cond: C_NEVER,     target: ST_IDLE};
            5'd15: w = '{op: OP_SWAP2,      cond: C_ALWAYS,    target: ST_REV};
            5'd16: w = '{op: OP_EMIT_INIT,  cond: C_NEVER,     target: ST_IDLE};
            5'd17: w = '{op: OP_RD_K,       cond: C_NEVER,     target: ST_IDLE};
            5'd18: w = '{op: OP_EMIT,       cond: C_OUT_BUSY,  target: ST_EMIT};
            5'd19: w = '{op: OP_NOP,        cond: C_K_MORE,    target: ST_RD_K};
            5'd20: w = '{op: OP_NOP,        cond: C_ALWAYS,    target: ST_IDLE};
            default: w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/next_lexicographic_permutation.sv
// top level of the next lexicographic permutation stepper
//
// Keeps a sequence of up to sixteen 8-bit elements in a small store; the
// first size_in_use of them are active (0 acts as 1, values above 16 act as
// 16). A write beat (tuser = 0) stores one element at the given position and
// produces nothing. An advance beat (tuser = 1) steps the active part to its
// next lexicographic permutation, repeated values counted as a multiset, and
// then emits every active element in index order, tlast on the final one and
// tuser = 1 on all of them, or tuser = 0 when the sequence was already
// descending and has been turned back to ascending order. A short
// microprogram runs the step over a store with one write and one read port,
// so the time per advance is set by that one read port: it grows with the
// elements scanned for the ascent and for the swap partner, with the swaps of
// the suffix reversal and with the emitted beats. No new beat is taken
// until the last result beat has been loaded into the output register.
// Store entries are undefined until written; size_in_use must only be
// changed while the block is idle.
module next_lexicographic_permutation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // size_in_use register write
    input  logic                            i_cfg_we,
    input  logic [nlp_pkg::SIZE_W-1:0]      i_cfg_wdata,
    // input beats
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [3:0] position, [11:4] value
    input  logic                            s_axis_tuser,   // action
    // result beats
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] element, [11:8] element_index
    output logic                            m_axis_tlast,   // last
    output logic                            m_axis_tuser    // advanced
);

    nlp_pkg::t_op     w_op;
    nlp_pkg::t_status w_status;

    // sequencer: program counter and jump decisions
    nlp_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    // datapath: store, scan indices, swap registers and output beat register
    nlp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/core/nlp_ram.sv
// generic single write port ram with one registered read port
module nlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/nlp_sequencer.sv
// step counter, microcode rom and conditional jump logic
module nlp_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nlp_pkg::t_status i_status,
    output nlp_pkg::t_op     o_op
);

    nlp_pkg::t_step  r_step;
    nlp_pkg::t_step  n_step;
    nlp_pkg::t_uword w_word;
    logic            w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= nlp_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_word = nlp_pkg::ucode(r_step);
        case (w_word.cond)
            nlp_pkg::C_NEVER:     w_take = 1'b0;
            nlp_pkg::C_ALWAYS:    w_take = 1'b1;
            nlp_pkg::C_NOT_START: w_take = !i_status.start;
            nlp_pkg::C_I_ZERO:    w_take = i_status.i_zero;
            nlp_pkg::C_I_NZ:      w_take = !i_status.i_zero;
            nlp_pkg::C_ASC:       w_take = i_status.asc;
            nlp_pkg::C_J_LE:      w_take = i_status.j_le;
            nlp_pkg::C_REV_DONE:  w_take = i_status.rev_done;
            nlp_pkg::C_OUT_BUSY:  w_take = i_status.out_busy;
            nlp_pkg::C_K_MORE:    w_take = i_status.k_more;
            default:              w_take = 1'b1;
        endcase
        n_step = w_take ? w_word.target : r_step + nlp_pkg::t_step'(1);
        o_op   = w_word.op;
    end

endmodule

>>> rtl/core/nlp_datapath.sv
// element store, index and value registers, and the output beat register
module nlp_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nlp_pkg::t_op                       i_op,
    output nlp_pkg::t_status                   o_status,
    input  logic                               i_cfg_we,
    input  logic [nlp_pkg::SIZE_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nlp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [nlp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser
);

    localparam int CW = nlp_pkg::CNT_W;
    localparam int AW = nlp_pkg::ADDR_W;
    localparam int EW = nlp_pkg::ELEM_W;

    logic [nlp_pkg::SIZE_W-1:0] r_size;
    logic [CW-1:0]              r_n, r_i, r_j, r_lo, r_hi, r_k;
    logic [EW-1:0]              r_prev, r_pivot, r_cur, r_a;
    logic                       r_moved;
    logic                       r_out_valid;
    logic [EW-1:0]              r_out_elem;
    logic [AW-1:0]              r_out_index;
    logic                       r_out_last;
    logic                       r_out_adv;

    logic [CW-1:0] w_len;
    logic [CW-1:0] w_i_m1;
    logic          w_accept;
    logic          w_load;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    nlp_ram #(
        .WIDTH (EW),
        .DEPTH (nlp_pkg::MAX_LENGTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // active length, clamped to one..store depth
    always_comb begin
        if (r_size == '0) begin
            w_len = CW'(1);
        end else if (32'(r_size) > nlp_pkg::MAX_LENGTH) begin
            w_len = CW'(nlp_pkg::MAX_LENGTH);
        end else begin
            w_len = CW'(r_size);
        end
    end

    assign s_axis_tready = (i_op == nlp_pkg::OP_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_i_m1        = r_i - CW'(1);

    assign o_status.start    = w_accept && (s_axis_tuser == nlp_pkg::ACT_ADVANCE);
    assign o_status.asc      = (w_rdata < r_prev);
    assign o_status.i_zero   = (r_i == '0);
    assign o_status.j_le     = (w_rdata <= r_pivot);
    assign o_status.rev_done = ((r_lo + CW'(1)) >= r_hi);
    assign o_status.out_busy = r_out_valid && !m_axis_tready;
    assign o_status.k_more   = (r_k < r_n);

    assign w_load = (i_op == nlp_pkg::OP_EMIT) && !o_status.out_busy;

    // store port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = s_axis_tdata[AW-1:0];
        w_wdata = s_axis_tdata[AW +: EW];
        w_raddr = r_k[AW-1:0];
        case (i_op)
            nlp_pkg::OP_IDLE: begin
                w_we = w_accept && (s_axis_tuser == nlp_pkg::ACT_WRITE);
            end
            nlp_pkg::OP_RD_I:   w_raddr = r_i[AW-1:0];
            nlp_pkg::OP_RD_IM1: w_raddr = w_i_m1[AW-1:0];
            nlp_pkg::OP_RD_J:   w_raddr = r_j[AW-1:0];
            nlp_pkg::OP_RD_LO:  w_raddr = r_lo[AW-1:0];
            nlp_pkg::OP_RD_HI:  w_raddr = r_hi[AW-1:0];
            nlp_pkg::OP_WR_PIV_J: begin
                w_we    = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_wdata = r_pivot;
            end
            nlp_pkg::OP_WR_CUR_IM1: begin
                w_we    = 1'b1;
                w_waddr = w_i_m1[AW-1:0];
                w_wdata = r_cur;
            end
            nlp_pkg::OP_SWAP1: begin
                w_we    = 1'b1;
                w_waddr = r_lo[AW-1:0];
                w_wdata = w_rdata;
            end
            nlp_pkg::OP_SWAP2: begin
                w_we    = 1'b1;
                w_waddr = r_hi[AW-1:0];
                w_wdata = r_a;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= nlp_pkg::SIZE_W'(nlp_pkg::SIZE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            nlp_pkg::OP_IDLE: begin
                if (o_status.start) begin
                    r_n <= w_len;
                    r_i <= w_len - CW'(1);
                    r_j <= w_len - CW'(1);
                end
            end
            nlp_pkg::OP_LD_PREV: r_prev <= w_rdata;
            nlp_pkg::OP_CMP_ASC: begin
                if (o_status.asc) begin
                    r_pivot <= w_rdata;
                end else begin
                    r_prev <= w_rdata;
                    r_i    <= w_i_m1;
                end
            end
            nlp_pkg::OP_WRAP: begin
                r_lo    <= '0;
                r_hi    <= r_n;
                r_moved <= 1'b0;
            end
            nlp_pkg::OP_TEST_J: begin
                if (o_status.j_le) begin
                    r_j <= r_j - CW'(1);
                end else begin
                    r_cur <= w_rdata;
                end
            end
            nlp_pkg::OP_WR_CUR_IM1: begin
                r_lo    <= r_i;
                r_hi    <= r_n;
                r_moved <= 1'b1;
            end
            nlp_pkg::OP_REV_CHK: begin
                if (!o_status.rev_done) begin
                    r_hi <= r_hi - CW'(1);
                end
            end
            nlp_pkg::OP_RD_HI:     r_a  <= w_rdata;
            nlp_pkg::OP_SWAP2:     r_lo <= r_lo + CW'(1);
            nlp_pkg::OP_EMIT_INIT: r_k  <= '0;
            nlp_pkg::OP_EMIT: begin
                if (w_load) begin
                    r_out_elem  <= w_rdata;
                    r_out_index <= r_k[AW-1:0];
                    r_out_last  <= ((r_k + CW'(1)) == r_n);
                    r_out_adv   <= r_moved;
                    r_k         <= r_k + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = nlp_pkg::OUT_TDATA_W'({r_out_index, r_out_elem});
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_adv;

    // a swap only ever touches two distinct entries
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == nlp_pkg::OP_SWAP1) |-> (r_lo < r_hi))
        else $error("reversal swap with crossed bounds");

    // the swap partner never lies left of the ascent
    a_partner_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == nlp_pkg::OP_TEST_J && !o_status.j_le) |-> (r_j >= r_i))
        else $error("swap partner left of ascent");

    // every emitted beat indexes an active element
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_k < r_n))
        else $error("emit index beyond active length");

    // the last mark closes the run: emission ends after it
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && ((r_k + CW'(1)) == r_n)) |=> ##1 !o_status.k_more)
        else $error("emission continues after last beat");

endmodule
